// File: hw/rtl/fecu_pkg.sv
package fecu_pkg;

    localparam int MEM_AW    = 11;
    localparam int MEM_DEPTH = 2048;
    localparam int BYTE_W    = 8;
    localparam int OP_W      = 5;
    localparam int IO_AW_MAX = 8;

    localparam logic [MEM_AW-1:0] MEM_LAST = 11'h7FF;

    typedef enum logic [1:0] {
        KIND_LOAD  = 2'd0,
        KIND_EXEC  = 2'd1,
        KIND_RDMEM = 2'd2,
        KIND_RDIO  = 2'd3
    } kind_t;

    localparam logic [OP_W-1:0] OP_WM  = 5'h01;
    localparam logic [OP_W-1:0] OP_RM  = 5'h02;
    localparam logic [OP_W-1:0] OP_BR  = 5'h03;
    localparam logic [OP_W-1:0] OP_RIO = 5'h04;
    localparam logic [OP_W-1:0] OP_WIO = 5'h05;
    localparam logic [OP_W-1:0] OP_WB  = 5'h06;
    localparam logic [OP_W-1:0] OP_WIB = 5'h07;
    localparam logic [OP_W-1:0] OP_EOP = 5'h1F;

    localparam logic [1:0] ST_RUN = 2'd0;
    localparam logic [1:0] ST_EOP = 2'd1;
    localparam logic [1:0] ST_ERR = 2'd2;

    typedef struct packed {
        logic              we;
        logic [MEM_AW-1:0] waddr;
        logic [BYTE_W-1:0] wdata;
        logic [MEM_AW-1:0] raddr;
    } mem_req_t;

    typedef struct packed {
        logic                 we;
        logic [IO_AW_MAX-1:0] waddr;
        logic [BYTE_W-1:0]    wdata;
        logic [IO_AW_MAX-1:0] raddr;
    } io_req_t;

    typedef struct packed {
        logic [MEM_AW-1:0] program_counter;
        logic [OP_W-1:0]   opcode;
        logic [MEM_AW-1:0] operand_value;
        logic [BYTE_W-1:0] buffer_reg;
        logic [BYTE_W-1:0] io_buffer_reg;
        logic [1:0]        run_status;
        logic [BYTE_W-1:0] read_value;
    } res_t;

endpackage

// File: hw/rtl/fecu_if.sv
interface fecu_in_if
    import fecu_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [1:0]        kind;
    logic [MEM_AW-1:0] address;
    logic [BYTE_W-1:0] data;

    modport source (output valid, kind, address, data, input ready);
    modport sink (input valid, kind, address, data, output ready);
endinterface

interface fecu_out_if
    import fecu_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [MEM_AW-1:0] program_counter;
    logic [OP_W-1:0]   opcode;
    logic [MEM_AW-1:0] operand_value;
    logic [BYTE_W-1:0] buffer_reg;
    logic [BYTE_W-1:0] io_buffer_reg;
    logic [1:0]        run_status;
    logic [BYTE_W-1:0] read_value;

    modport source (output valid, program_counter, opcode, operand_value, buffer_reg,
                    io_buffer_reg, run_status, read_value, input ready);
    modport sink (input valid, program_counter, opcode, operand_value, buffer_reg,
                  io_buffer_reg, run_status, read_value, output ready);
endinterface

// File: hw/rtl/fecu_ram.sv
module fecu_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2048,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: hw/rtl/fecu_core.sv
module fecu_core
    import fecu_pkg::*;
#(
    parameter int IO_DEPTH = 32
) (
    input  logic              clk,
    input  logic              rst_n,
    fecu_in_if.sink           cmd,
    output mem_req_t          mreq,
    input  logic [BYTE_W-1:0] m_rdata,
    output io_req_t           ioreq,
    input  logic [BYTE_W-1:0] io_rdata,
    input  logic              out_free,
    output logic              res_valid,
    output res_t              res
);

    localparam int IO_AW = (IO_DEPTH > 1) ? $clog2(IO_DEPTH) : 1;

    typedef enum logic [8:0] {
        S_CLEAR    = 9'b000000001,
        S_IDLE     = 9'b000000010,
        S_FETCH_HI = 9'b000000100,
        S_FETCH_LO = 9'b000001000,
        S_EXEC_MEM = 9'b000010000,
        S_EXEC_IO  = 9'b000100000,
        S_READ_MEM = 9'b001000000,
        S_READ_IO  = 9'b010000000,
        S_DONE     = 9'b100000000
    } state_t;

    state_t            state_reg, state_next;
    logic [MEM_AW-1:0] clr_addr_reg, clr_addr_next;
    logic [MEM_AW-1:0] pc_reg, pc_next;
    logic [BYTE_W-1:0] mbr_reg, mbr_next;
    logic [BYTE_W-1:0] iobr_reg, iobr_next;
    logic [1:0]        halt_reg, halt_next;
    logic [BYTE_W-1:0] hi_reg, hi_next;
    logic [OP_W-1:0]   op_reg, op_next;
    logic [MEM_AW-1:0] arg_reg, arg_next;
    logic [BYTE_W-1:0] rv_reg, rv_next;
    logic              io_hit_reg, io_hit_next;
    logic              io_valid_reg [IO_DEPTH];
    logic              io_valid_next [IO_DEPTH];
    logic              take;

    // An IO address hits when it lies inside the buffer and the cell has been written.
    function automatic logic io_in_range(input logic [IO_AW_MAX-1:0] a);
        return ({1'b0, a} < 9'(IO_DEPTH));
    endfunction

    assign cmd.ready = (state_reg == S_IDLE) || ((state_reg == S_DONE) && out_free);
    assign take      = cmd.valid && cmd.ready;
    assign res_valid = (state_reg == S_DONE) && out_free;

    always_comb
    begin
        res.program_counter = pc_reg;
        res.opcode          = op_reg;
        res.operand_value   = arg_reg;
        res.buffer_reg      = mbr_reg;
        res.io_buffer_reg   = iobr_reg;
        res.run_status      = halt_reg;
        res.read_value      = rv_reg;
    end

    always_comb
    begin
        logic [MEM_AW-1:0]    arg;
        logic [OP_W-1:0]      op;
        logic [IO_AW_MAX-1:0] io_a;

        state_next    = state_reg;
        clr_addr_next = clr_addr_reg;
        pc_next       = pc_reg;
        mbr_next      = mbr_reg;
        iobr_next     = iobr_reg;
        halt_next     = halt_reg;
        hi_next       = hi_reg;
        op_next       = op_reg;
        arg_next      = arg_reg;
        rv_next       = rv_reg;
        io_hit_next   = io_hit_reg;
        io_valid_next = io_valid_reg;
        mreq          = '0;
        mreq.raddr    = pc_reg;
        ioreq         = '0;
        op            = m_rdata[BYTE_W-1 -: OP_W];
        arg           = {m_rdata[BYTE_W-OP_W-1:0], m_rdata};
        arg           = {hi_reg[BYTE_W-OP_W-1:0], m_rdata};
        op            = hi_reg[BYTE_W-1 -: OP_W];
        io_a          = arg[IO_AW_MAX-1:0];

        unique case (state_reg)
            S_CLEAR:
            begin
                mreq.we       = 1'b1;
                mreq.waddr    = clr_addr_reg;
                mreq.wdata    = '0;
                clr_addr_next = clr_addr_reg + 11'd1;
                if (clr_addr_reg == MEM_LAST)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                state_next = S_IDLE;
            end
            S_FETCH_HI:
            begin
                hi_next    = m_rdata;
                mreq.raddr = pc_reg + 11'd1;
                state_next = S_FETCH_LO;
            end
            S_FETCH_LO:
            begin
                op_next    = op;
                arg_next   = arg;
                pc_next    = pc_reg + 11'd2;
                state_next = S_DONE;
                unique case (op)
                    OP_WM:
                    begin
                        mreq.we    = 1'b1;
                        mreq.waddr = arg;
                        mreq.wdata = mbr_reg;
                    end
                    OP_RM:
                    begin
                        mreq.raddr = arg;
                        state_next = S_EXEC_MEM;
                    end
                    OP_BR:
                    begin
                        pc_next = arg;
                    end
                    OP_RIO:
                    begin
                        ioreq.raddr = io_a;
                        io_hit_next = io_in_range(io_a) && io_valid_reg[io_a[IO_AW-1:0]];
                        state_next  = S_EXEC_IO;
                    end
                    OP_WIO:
                    begin
                        if (io_in_range(io_a))
                        begin
                            ioreq.we    = 1'b1;
                            ioreq.waddr = io_a;
                            ioreq.wdata = iobr_reg;
                            io_valid_next[io_a[IO_AW-1:0]] = 1'b1;
                        end
                    end
                    OP_WB:
                    begin
                        mbr_next = arg[BYTE_W-1:0];
                    end
                    OP_WIB:
                    begin
                        iobr_next = arg[BYTE_W-1:0];
                    end
                    OP_EOP:
                    begin
                        halt_next = ST_EOP;
                    end
                    default:
                    begin
                        halt_next = ST_ERR;
                    end
                endcase
            end
            S_EXEC_MEM:
            begin
                mbr_next   = m_rdata;
                state_next = S_DONE;
            end
            S_EXEC_IO:
            begin
                iobr_next  = io_hit_reg ? io_rdata : '0;
                state_next = S_DONE;
            end
            S_READ_MEM:
            begin
                rv_next    = m_rdata;
                state_next = S_DONE;
            end
            S_READ_IO:
            begin
                rv_next    = io_hit_reg ? io_rdata : '0;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // A new transaction is only taken in IDLE or while the finished result leaves.
        if (take)
        begin
            op_next  = '0;
            arg_next = '0;
            rv_next  = '0;
            io_a     = {3'b000, cmd.address[4:0]};
            unique case (kind_t'(cmd.kind))
                KIND_LOAD:
                begin
                    mreq.we    = 1'b1;
                    mreq.waddr = cmd.address;
                    mreq.wdata = cmd.data;
                    state_next = S_DONE;
                end
                KIND_EXEC:
                begin
                    if (halt_reg != ST_RUN)
                    begin
                        state_next = S_DONE;
                    end
                    else
                    begin
                        mreq.raddr = pc_reg;
                        state_next = S_FETCH_HI;
                    end
                end
                KIND_RDMEM:
                begin
                    mreq.raddr = cmd.address;
                    state_next = S_READ_MEM;
                end
                KIND_RDIO:
                begin
                    ioreq.raddr = io_a;
                    io_hit_next = io_in_range(io_a) && io_valid_reg[io_a[IO_AW-1:0]];
                    state_next  = S_READ_IO;
                end
                default:
                begin
                    state_next = S_DONE;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_CLEAR;
            clr_addr_reg <= '0;
            pc_reg       <= '0;
            mbr_reg      <= '0;
            iobr_reg     <= '0;
            halt_reg     <= ST_RUN;
            for (int i = 0; i < IO_DEPTH; i++)
            begin
                io_valid_reg[i] <= 1'b0;
            end
        end
        else
        begin
            state_reg    <= state_next;
            clr_addr_reg <= clr_addr_next;
            pc_reg       <= pc_next;
            mbr_reg      <= mbr_next;
            iobr_reg     <= iobr_next;
            halt_reg     <= halt_next;
            io_valid_reg <= io_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hi_reg     <= hi_next;
        op_reg     <= op_next;
        arg_reg    <= arg_next;
        rv_reg     <= rv_next;
        io_hit_reg <= io_hit_next;
    end

endmodule

// File: hw/rtl/fetch_execute_control_unit.sv
// Fetch/execute control unit of a small teaching machine.
// The cmd channel carries one transaction per item: a byte load into the
// main store, one instruction step, a main store read or an IO cell read.
// The rsp channel returns exactly one transaction per item, in order, with
// the program counter, MBR, IOBR and run status after the item, the opcode
// and operand of an executed instruction and the byte of a read item.
// From acceptance to the output register a load or a halted step passes
// only the DONE state; a read item passes READ_MEM or READ_IO before it,
// an instruction FETCH_HI and FETCH_LO, and one that reads the main store
// or the IO buffer then EXEC_MEM or EXEC_IO. The single read port of the
// main store sets this order: an instruction fetches its two bytes in turn,
// and a data access follows the fetch. A new item is taken in the cycle its
// predecessor's result moves to the output register, not while it is in work.
// After reset the main store is swept to zero, one byte a cycle, over all
// 2048 bytes, during which cmd.ready stays low; the IO buffer reads zero until
// each cell is written. When the receiver stalls, one result waits in the
// output register while the next item is worked on; that item then waits
// in its final step and cmd.ready falls until the output register empties.
module fetch_execute_control_unit
    import fecu_pkg::*;
#(
    parameter int IO_DEPTH = 32
) (
    input  logic       clk,
    input  logic       rst_n,
    fecu_in_if.sink    cmd,
    fecu_out_if.source rsp
);

    localparam int IO_AW = (IO_DEPTH > 1) ? $clog2(IO_DEPTH) : 1;

    mem_req_t          mreq;
    io_req_t           ioreq;
    logic [BYTE_W-1:0] m_rdata;
    logic [BYTE_W-1:0] io_rdata;
    logic              res_valid;
    res_t              res;
    logic              out_valid_reg, out_valid_next;
    res_t              out_data_reg;
    logic              out_free;

    // The output register is free when empty or when its transaction leaves now.
    assign out_free = !out_valid_reg || rsp.ready;

    fecu_core #(
        .IO_DEPTH (IO_DEPTH)
    ) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .mreq      (mreq),
        .m_rdata   (m_rdata),
        .ioreq     (ioreq),
        .io_rdata  (io_rdata),
        .out_free  (out_free),
        .res_valid (res_valid),
        .res       (res)
    );

    fecu_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (MEM_DEPTH)
    ) u_main_ram (
        .clk   (clk),
        .we    (mreq.we),
        .waddr (mreq.waddr),
        .wdata (mreq.wdata),
        .raddr (mreq.raddr),
        .rdata (m_rdata)
    );

    fecu_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (IO_DEPTH)
    ) u_io_ram (
        .clk   (clk),
        .we    (ioreq.we),
        .waddr (ioreq.waddr[IO_AW-1:0]),
        .wdata (ioreq.wdata),
        .raddr (ioreq.raddr[IO_AW-1:0]),
        .rdata (io_rdata)
    );

    always_comb
    begin
        priority if (res_valid)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid)
        begin
            out_data_reg <= res;
        end
    end

    assign rsp.valid           = out_valid_reg;
    assign rsp.program_counter = out_data_reg.program_counter;
    assign rsp.opcode          = out_data_reg.opcode;
    assign rsp.operand_value   = out_data_reg.operand_value;
    assign rsp.buffer_reg      = out_data_reg.buffer_reg;
    assign rsp.io_buffer_reg   = out_data_reg.io_buffer_reg;
    assign rsp.run_status      = out_data_reg.run_status;
    assign rsp.read_value      = out_data_reg.read_value;

endmodule
